@@ rtl/core/conv2d_pkg.sv @@
// ----------------------------------------------------------------------------
// conv2d package
// Shared types and constants for the multi-channel convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package conv2d_pkg;

   localparam int MAX_ROWS_DEF    = 32;
   localparam int MAX_COLS_DEF    = 32;
   localparam int MAX_DEPTH_DEF   = 8;
   localparam int MAX_KERNEL_DEF  = 5;
   localparam int MAX_FILTERS_DEF = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] REG_INPUT_ROWS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_COLS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_DEPTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_ROWS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_COLS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_COUNT = 3'd5;

   localparam logic [1:0] ACT_SAMPLE  = 2'd0;
   localparam logic [1:0] ACT_WEIGHT  = 2'd1;
   localparam logic [1:0] ACT_BIAS    = 2'd2;
   localparam logic [1:0] ACT_COMPUTE = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_SAT   = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [3:0]         filter_index;
      logic [2:0]         channel;
      logic [4:0]         row_index;
      logic [4:0]         col_index;
      logic signed [15:0] sample_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] conv_value;
      logic [1:0]         status;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/conv2d_multi_filter_bias.sv @@
// response: a compute transaction runs the MAC loop, then the drain, bias and saturate states,
// before raising rsp_valid; an out-of-range compute raises it in the cycle after acceptance
// throughput: one transaction at a time, set by the single multiply-accumulate
// loop over the input and weight memories (one read port each); loads are accepted only while idle
// reset: synchronous; registers return to 32,32,1,3,3,1, memories keep contents
// ----------------------------------------------------------------------------
// conv2d_multi_filter_bias
// Valid stride-one multi-channel 2D convolution with per-filter bias, Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module conv2d_multi_filter_bias
   import conv2d_pkg::*;
#(
   parameter int MAX_ROWS    = MAX_ROWS_DEF,
   parameter int MAX_COLS    = MAX_COLS_DEF,
   parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
   parameter int MAX_KERNEL  = MAX_KERNEL_DEF,
   parameter int MAX_FILTERS = MAX_FILTERS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int KW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int FW  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
   localparam int IN_WORDS = MAX_DEPTH * MAX_ROWS * MAX_COLS;
   localparam int W_WORDS  = MAX_FILTERS * MAX_DEPTH * MAX_KERNEL * MAX_KERNEL;
   localparam int IAW = (IN_WORDS > 1) ? $clog2(IN_WORDS) : 1;
   localparam int WAW = (W_WORDS > 1) ? $clog2(W_WORDS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAC, ST_DRAIN, ST_BIAS, ST_SAT, ST_OUT
   } state_type;

   // configuration registers
   logic [5:0] in_rows_ff, in_cols_ff;
   logic [3:0] in_depth_ff;
   logic [2:0] k_rows_ff, k_cols_ff;
   logic [4:0] f_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_rows_ff  <= 6'd32;
         in_cols_ff  <= 6'd32;
         in_depth_ff <= 4'd1;
         k_rows_ff   <= 3'd3;
         k_cols_ff   <= 3'd3;
         f_count_ff  <= 5'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_INPUT_ROWS:   in_rows_ff  <= csr_wdata;
            REG_INPUT_COLS:   in_cols_ff  <= csr_wdata;
            REG_INPUT_DEPTH:  in_depth_ff <= csr_wdata[3:0];
            REG_KERNEL_ROWS:  k_rows_ff   <= csr_wdata[2:0];
            REG_KERNEL_COLS:  k_cols_ff   <= csr_wdata[2:0];
            REG_FILTER_COUNT: f_count_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // clamp registers: zero counts as one, above max counts as max
   function automatic logic [9:0] clampv(input logic [9:0] v, input logic [9:0] hi);
      logic [9:0] r;
      begin
         r = (v == 10'd0) ? 10'd1 : v;
         if (r > hi) r = hi;
         return r;
      end
   endfunction

   logic [9:0] ir, ic, dep, kr, kc, nf;
   assign ir  = clampv({4'd0, in_rows_ff}, 10'(MAX_ROWS));
   assign ic  = clampv({4'd0, in_cols_ff}, 10'(MAX_COLS));
   assign dep = clampv({6'd0, in_depth_ff}, 10'(MAX_DEPTH));
   assign kr  = clampv({7'd0, k_rows_ff}, 10'(MAX_KERNEL));
   assign kc  = clampv({7'd0, k_cols_ff}, 10'(MAX_KERNEL));
   assign nf  = clampv({5'd0, f_count_ff}, 10'(MAX_FILTERS));

   // memories
   logic [15:0] in_mem [IN_WORDS];
   logic [15:0] w_mem  [W_WORDS];
   logic [15:0] b_mem  [MAX_FILTERS];
   logic [15:0] in_rd_ff, w_rd_ff, b_rd_ff;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   logic [9:0] q_f, q_ch, q_r, q_c;
   assign q_f  = {6'd0, req_data.filter_index};
   assign q_ch = {7'd0, req_data.channel};
   assign q_r  = {5'd0, req_data.row_index};
   assign q_c  = {5'd0, req_data.col_index};

   logic [IAW-1:0] wr_in_addr;
   logic [WAW-1:0] wr_w_addr;
   assign wr_in_addr = IAW'((q_ch * MAX_ROWS + q_r) * MAX_COLS + q_c);
   assign wr_w_addr  = WAW'(((q_f * MAX_DEPTH + q_ch) * MAX_KERNEL + q_r)
                            * MAX_KERNEL + q_c);

   // load writes into the stores
   always_ff @(posedge clock) begin
      if (req_fire && req_data.action == ACT_SAMPLE && q_ch < 10'(MAX_DEPTH)
          && q_r < 10'(MAX_ROWS) && q_c < 10'(MAX_COLS))
         in_mem[wr_in_addr] <= req_data.sample_value;
      if (req_fire && req_data.action == ACT_WEIGHT && q_f < 10'(MAX_FILTERS)
          && q_ch < 10'(MAX_DEPTH) && q_r < 10'(MAX_KERNEL) && q_c < 10'(MAX_KERNEL))
         w_mem[wr_w_addr] <= req_data.sample_value;
      if (req_fire && req_data.action == ACT_BIAS && q_f < 10'(MAX_FILTERS))
         b_mem[q_f[FW-1:0]] <= req_data.sample_value;
   end

   // sequencer state
   state_type    state_ff;
   logic [FW-1:0] f_ff;
   logic [RW-1:0] r0_ff;
   logic [CW-1:0] c0_ff;
   logic [KW-1:0] i_ff, j_ff;
   logic [DW-1:0] d_ff;
   logic         rd_vld_ff, prod_vld_ff;
   logic signed [31:0] prod_ff;
   logic signed [47:0] acc_ff;
   rsp_type      rsp_ff;

   logic [9:0] ri, cj;
   assign ri = 10'(r0_ff) + 10'(i_ff);
   assign cj = 10'(c0_ff) + 10'(j_ff);

   logic [IAW-1:0] rd_in_addr;
   logic [WAW-1:0] rd_w_addr;
   assign rd_in_addr = IAW'((10'(d_ff) * MAX_ROWS + ri) * MAX_COLS + cj);
   assign rd_w_addr  = WAW'(((10'(f_ff) * MAX_DEPTH + 10'(d_ff)) * MAX_KERNEL
                             + 10'(i_ff)) * MAX_KERNEL + 10'(j_ff));

   // synchronous reads, one per cycle during the loop
   always_ff @(posedge clock) begin
      in_rd_ff <= in_mem[rd_in_addr];
      w_rd_ff  <= w_mem[rd_w_addr];
      b_rd_ff  <= b_mem[f_ff];
   end

   logic out_range;
   assign out_range = (q_f >= nf) || (kr > ir) || (kc > ic) ||
                      (q_r > ir - kr) || (q_c > ic - kc);

   logic last_idx;
   assign last_idx = (10'(d_ff) == dep - 10'd1) && (10'(j_ff) == kc - 10'd1)
                     && (10'(i_ff) == kr - 10'd1);

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;

   logic signed [47:0] bias_ext;
   assign bias_ext = 48'(signed'(b_rd_ff)) <<< 8;

   // control and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= (state_ff == ST_MAC);
         prod_vld_ff <= rd_vld_ff;
         prod_ff     <= signed'(in_rd_ff) * signed'(w_rd_ff);
         if (prod_vld_ff) acc_ff <= acc_ff + 48'(prod_ff);
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_data.action == ACT_COMPUTE) begin
                  f_ff   <= req_data.filter_index[FW-1:0];
                  r0_ff  <= RW'(req_data.row_index);
                  c0_ff  <= CW'(req_data.col_index);
                  i_ff   <= '0;
                  j_ff   <= '0;
                  d_ff   <= '0;
                  acc_ff <= '0;
                  if (out_range) begin
                     rsp_ff   <= '{conv_value: 32'sd0, status: STAT_RANGE};
                     state_ff <= ST_OUT;
                  end else begin
                     state_ff <= ST_MAC;
                  end
               end
            end
            ST_MAC: begin
               if (last_idx) begin
                  state_ff <= ST_DRAIN;
               end else if (10'(d_ff) == dep - 10'd1) begin
                  d_ff <= '0;
                  if (10'(j_ff) == kc - 10'd1) begin
                     j_ff <= '0;
                     i_ff <= i_ff + 1'b1;
                  end else begin
                     j_ff <= j_ff + 1'b1;
                  end
               end else begin
                  d_ff <= d_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (!rd_vld_ff && !prod_vld_ff) state_ff <= ST_BIAS;
            end
            ST_BIAS: begin
               acc_ff   <= acc_ff + bias_ext;
               state_ff <= ST_SAT;
            end
            ST_SAT: begin
               if (acc_ff > 48'sd2147483647)
                  rsp_ff <= '{conv_value: 32'h7fffffff, status: STAT_SAT};
               else if (acc_ff < -48'sd2147483648)
                  rsp_ff <= '{conv_value: 32'h80000000, status: STAT_SAT};
               else
                  rsp_ff <= '{conv_value: acc_ff[31:0], status: STAT_OK};
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");
   a_drain_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BIAS) |-> !prod_vld_ff && !rd_vld_ff)
      else $error("bias added before products drained");
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STAT_RANGE) |-> rsp_data.conv_value == 0)
      else $error("out of range result not zero");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// conv2d_multi_filter_bias testbench
// Loads samples, weights and biases, runs compute transactions under several
// geometries and compares each result against an in-bench convolution model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
   import conv2d_pkg::*;
;

   localparam int MR = MAX_ROWS_DEF;
   localparam int MC = MAX_COLS_DEF;
   localparam int MD = MAX_DEPTH_DEF;
   localparam int MK = MAX_KERNEL_DEF;
   localparam int MF = MAX_FILTERS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   // working footprint that random geometries stay inside
   localparam int LR = 8;
   localparam int LC = 8;
   localparam int LD = 2;
   localparam int LK = 3;
   localparam int LF = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   conv2d_multi_filter_bias dut (.*);

   always #5 clock = ~clock;

   // shadow stores and geometry
   logic signed [15:0] pix_mem [MD][MR][MC];
   logic signed [15:0] coef_mem [MF][MD][MK][MK];
   logic signed [15:0] bias_mem [MF];
   int unsigned geo [6];
   rsp_type conv_expected [$];
   int error_count = 0;
   int result_count = 0;
   int compute_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // predicted result of one compute transaction
   function automatic rsp_type conv_predict(input req_type t);
      int unsigned ir, ic, dep, kr, kc, nf;
      longint acc;
      rsp_type res;
      ir = clamp_reg(geo[0], MR);
      ic = clamp_reg(geo[1], MC);
      dep = clamp_reg(geo[2], MD);
      kr = clamp_reg(geo[3], MK);
      kc = clamp_reg(geo[4], MK);
      nf = clamp_reg(geo[5], MF);
      res = '0;
      if (t.filter_index >= nf || kr > ir || kc > ic || t.row_index > ir - kr ||
          t.col_index > ic - kc) begin
         res.status = STAT_RANGE;
         return res;
      end
      acc = 0;
      for (int i = 0; i < kr; i++)
         for (int j = 0; j < kc; j++)
            for (int d = 0; d < dep; d++)
               acc += longint'(pix_mem[d][t.row_index+i][t.col_index+j]) *
                      longint'(coef_mem[t.filter_index][d][i][j]);
      acc += longint'(bias_mem[t.filter_index]) * 256;
      res.status = STAT_OK;
      if (acc > 64'sd2147483647) begin
         acc = 64'sd2147483647;
         res.status = STAT_SAT;
      end else if (acc < -64'sd2147483648) begin
         acc = -64'sd2147483648;
         res.status = STAT_SAT;
      end
      res.conv_value = acc[31:0];
      return res;
   endfunction

   // update shadow stores or queue an expectation
   function automatic void conv_apply(input req_type t);
      case (t.action)
         ACT_SAMPLE: pix_mem[t.channel][t.row_index][t.col_index] = t.sample_value;
         ACT_WEIGHT: if (t.row_index < MK && t.col_index < MK)
            coef_mem[t.filter_index][t.channel][t.row_index][t.col_index] = t.sample_value;
         ACT_BIAS: bias_mem[t.filter_index] = t.sample_value;
         default: begin
            conv_expected.push_back(conv_predict(t));
            compute_count++;
         end
      endcase
   endfunction

   // valid stays high after acceptance until an idle cycle or a drain drops it
   task automatic send_item(input req_type t);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      conv_apply(t);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[CSR_DATA_W-1:0];
      @(posedge clock);
      geo[idx] = v & ((idx == REG_INPUT_DEPTH) ? 32'hF :
                      (idx == REG_KERNEL_ROWS || idx == REG_KERNEL_COLS) ? 32'h7 :
                      (idx == REG_FILTER_COUNT) ? 32'h1F : 32'h3F);
   endtask

   // stop sending and wait until nothing is pending and the block has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (conv_expected.size() != 0) @(posedge clock);
      repeat (MK * MK * MD + 20) @(posedge clock);
   endtask

   task automatic set_geometry(input int unsigned r, c, d, kr, kc, nf);
      drain();
      write_csr(REG_INPUT_ROWS, r);
      write_csr(REG_INPUT_COLS, c);
      write_csr(REG_INPUT_DEPTH, d);
      write_csr(REG_KERNEL_ROWS, kr);
      write_csr(REG_KERNEL_COLS, kc);
      write_csr(REG_FILTER_COUNT, nf);
      csr_we <= 1'b0;
   endtask

   function automatic req_type make_req(input logic [1:0] a, input int f, ch, r, c,
                                        input int v);
      req_type t;
      t.action = a;
      t.filter_index = f[3:0];
      t.channel = ch[2:0];
      t.row_index = r[4:0];
      t.col_index = c[4:0];
      t.sample_value = v[15:0];
      return t;
   endfunction

   // fill a corner of the stores so no compute inside it reads an unwritten word
   task automatic load_block(input int mode, input int nr, nc, nd, nfl);
      int v;
      for (int d = 0; d < nd; d++)
         for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++) begin
               v = (mode == 1) ? 32767 : (mode == 2) ? -32768 : $urandom;
               send_item(make_req(ACT_SAMPLE, $urandom, d, r, c, v));
            end
      for (int f = 0; f < nfl; f++) begin
         for (int d = 0; d < nd; d++)
            for (int r = 0; r < LK; r++)
               for (int c = 0; c < LK; c++) begin
                  v = (mode != 0) ? 32767 : $urandom;
                  send_item(make_req(ACT_WEIGHT, f, d, r, c, v));
               end
         v = (mode == 1) ? 32767 : (mode == 2) ? -32768 : $urandom;
         send_item(make_req(ACT_BIAS, f, $urandom, $urandom, $urandom, v));
      end
   endtask

   function automatic req_type rand_item();
      int unsigned k;
      k = $urandom_range(9, 0);
      if (k < 6)
         return make_req(ACT_COMPUTE, $urandom_range(clamp_reg(geo[5], MF), 0),
                         $urandom, $urandom_range(LR - 1, 0), $urandom_range(LC - 1, 0),
                         $urandom);
      else if (k == 6)
         return make_req(ACT_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (k == 7)
         return make_req(ACT_WEIGHT, $urandom, $urandom, $urandom_range(7, 0),
                         $urandom_range(7, 0), $urandom);
      else if (k == 8)
         return make_req(ACT_BIAS, $urandom, $urandom, $urandom, $urandom, $urandom);
      return make_req(ACT_COMPUTE, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   task automatic test_saturation();
      // all positive extremes saturate high; a row offset of one is out of range
      load_block(1, 3, 3, 2, 1);
      set_geometry(3, 3, 2, 3, 3, 1);
      send_item(make_req(ACT_COMPUTE, 0, 0, 0, 0, 0));
      send_item(make_req(ACT_COMPUTE, 0, 0, 1, 0, 0));
      // negative samples and bias saturate low
      load_block(2, 3, 3, 2, 1);
      send_item(make_req(ACT_COMPUTE, 0, 0, 0, 0, 0));
   endtask

   task automatic test_directed();
      set_geometry(LR, LC, 1, 3, 3, 1);
      send_item(make_req(ACT_COMPUTE, 0, 0, 0, 0, 0));
      send_item(make_req(ACT_COMPUTE, 0, 7, LR - 3, LC - 3, -1));
      send_item(make_req(ACT_COMPUTE, 0, 0, LR - 2, 0, 0));
      send_item(make_req(ACT_COMPUTE, 0, 0, 0, LC - 2, 0));
      send_item(make_req(ACT_COMPUTE, 1, 0, 0, 0, 0));
      send_item(make_req(ACT_WEIGHT, 0, 0, 7, 7, 12345));
      set_geometry(1, 1, 1, 1, 1, 1);
      send_item(make_req(ACT_COMPUTE, 0, 0, 0, 0, 0));
      send_item(make_req(ACT_COMPUTE, 0, 0, 1, 0, 0));
      // kernel larger than the input
      set_geometry(2, 2, 1, 3, 3, LF);
      send_item(make_req(ACT_COMPUTE, 0, 0, 0, 0, 0));
      set_geometry(LR, LC, LD, 3, 3, LF);
      send_item(make_req(ACT_COMPUTE, LF - 1, 0, LR - 3, LC - 3, 0));
      // register values of zero and above the maximum
      for (int c = 0; c < MK; c++) begin
         send_item(make_req(ACT_SAMPLE, 0, 0, 0, MC - MK + c, $urandom));
         send_item(make_req(ACT_WEIGHT, MF - 1, 0, 0, c, $urandom));
      end
      send_item(make_req(ACT_BIAS, MF - 1, 0, 0, 0, $urandom));
      set_geometry(0, 63, 0, 0, 7, 31);
      send_item(make_req(ACT_COMPUTE, MF - 1, 0, 0, MC - MK, 0));
      send_item(make_req(ACT_COMPUTE, MF - 1, 0, 0, MC - MK + 1, 0));
      send_item(make_req(ACT_COMPUTE, 0, 0, 1, 0, 0));
      for (int d = 0; d < MD; d++) begin
         send_item(make_req(ACT_SAMPLE, 0, d, 0, 0, $urandom));
         send_item(make_req(ACT_WEIGHT, 0, d, 0, 0, $urandom));
      end
      set_geometry(1, 1, 15, 1, 1, 1);
      send_item(make_req(ACT_COMPUTE, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0) begin
            set_geometry($urandom_range(LR, 1), $urandom_range(LC, 1), $urandom_range(LD, 1),
                         $urandom_range(LK, 1), $urandom_range(LK, 1), $urandom_range(LF, 1));
         end
         send_item(rand_item());
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         rsp_ready <= (recv_idle_pct == 0) || ($urandom_range(99, 0) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (conv_expected.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               want = conv_expected.pop_front();
               if (rsp_data.conv_value !== want.conv_value)
                  report_mismatch($sformatf("conv_value %0d expected %0d",
                                            rsp_data.conv_value, want.conv_value));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d expected %0d",
                                            rsp_data.status, want.status));
            end
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results pending", conv_expected.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      geo = '{32, 32, 1, 3, 3, 1};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_saturation();
      load_block(0, LR, LC, LD, LF);
      test_directed();
      drain();
      send_idle_pct = 28;
      recv_idle_pct = 76;
      test_random(140);
      drain();
      send_idle_pct = 76;
      recv_idle_pct = 28;
      test_random(140);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(140);
      drain();
      $display("covered %0d compute transactions, %0d results, several geometries",
               compute_count, result_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
